/* design/circular_deque_core_defines.svh */
// Assertion macros shared by the circular deque modules.
`ifndef CIRCULAR_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked check, switched off while reset is asserted.
`define CDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CDQ_ASSERT(label, prop, msg)
`define CDQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* design/cdq_pkg.sv */
// Types, sizes and codes shared by the circular deque modules.
package cdq_pkg;

    // Built depth of the slot store and the widths that follow from it.
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed field widths of the channels and the register.
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;
    localparam int CAP_W   = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request codes carried by an input item.
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic finish;
    } cdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
    } cdq_stat_t;

endpackage

/* design/cdq_in_if.sv */
// Input channel: one request item per handshake.
interface cdq_in_if;
    logic                              valid;
    logic                              ready;
    logic [cdq_pkg::MODE_W-1:0]        mode;
    logic signed [cdq_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output mode, output data_in, input ready);
    modport sink   (input valid, input mode, input data_in, output ready);
endinterface

/* design/cdq_out_if.sv */
// Output channel: one result item per handshake.
interface cdq_out_if;
    logic                              valid;
    logic                              ready;
    logic [cdq_pkg::STAT_W-1:0]        status;
    logic signed [cdq_pkg::DATA_W-1:0] popped_value;
    logic signed [cdq_pkg::DATA_W-1:0] front_value;
    logic signed [cdq_pkg::DATA_W-1:0] rear_value;
    logic [cdq_pkg::ENTRY_W-1:0]       entry_count;
    logic                              is_empty;
    logic                              is_full;

    modport source (output valid, output status, output popped_value, output front_value,
                    output rear_value, output entry_count, output is_empty,
                    output is_full, input ready);
    modport sink   (input valid, input status, input popped_value, input front_value,
                    input rear_value, input entry_count, input is_empty,
                    input is_full, output ready);
endinterface

/* design/cdq_ctrl.sv */
// Controller state machine: sequences accept, store read and result delivery.
`include "circular_deque_core_defines.svh"

module cdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    input  cdq_pkg::cdq_stat_t  stat,
    output cdq_pkg::cdq_cmd_t   cmd,
    output logic                in_ready,
    output logic                out_valid
);

    cdq_pkg::state_t state_reg;
    cdq_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command outputs.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = stat.need_read ? cdq_pkg::S_READ : cdq_pkg::S_DONE;
                end
            end
            cdq_pkg::S_READ:
            begin
                // The store read data is ready; fold it into the cached ends.
                cmd.finish = 1'b1;
                state_next = cdq_pkg::S_DONE;
            end
            cdq_pkg::S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    // A new item is never taken while a result is on offer.
    `CDQ_ASSERT_ALWAYS(a_ready_valid_excl, !(in_ready && out_valid), "ready and valid both high")
    // A pop that reads the store always passes through the read step.
    `CDQ_ASSERT(a_read_follows, cmd.take && stat.need_read |=> cmd.finish, "read step skipped")
    // The read step is always followed by the result on offer.
    `CDQ_ASSERT(a_done_follows, cmd.finish |=> out_valid, "result not offered after read")

endmodule

/* design/cdq_dpath.sv */
// Datapath: slot store, indices, count, cached ends and the result registers.
`include "circular_deque_core_defines.svh"

module cdq_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic [cdq_pkg::MODE_W-1:0]    mode,
    input  logic [cdq_pkg::DATA_W-1:0]    data_in,
    input  cdq_pkg::cdq_cmd_t             cmd,
    output cdq_pkg::cdq_stat_t            stat,
    output logic [cdq_pkg::STAT_W-1:0]    status,
    output logic [cdq_pkg::DATA_W-1:0]    popped_value,
    output logic [cdq_pkg::DATA_W-1:0]    front_value,
    output logic [cdq_pkg::DATA_W-1:0]    rear_value,
    output logic [cdq_pkg::ENTRY_W-1:0]   entry_count,
    output logic                          is_empty,
    output logic                          is_full
);

    localparam int IDX_W  = cdq_pkg::IDX_W;
    localparam int CNT_W  = cdq_pkg::CNT_W;
    localparam int DATA_W = cdq_pkg::DATA_W;

    // Control state.
    logic [cdq_pkg::CAP_W-1:0] cap_reg;
    logic [cdq_pkg::CAP_W-1:0] cap_next;
    logic [IDX_W-1:0]          head_reg;
    logic [IDX_W-1:0]          head_next;
    logic [IDX_W-1:0]          tail_reg;
    logic [IDX_W-1:0]          tail_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    // Payload state.
    logic [DATA_W-1:0]         front_reg;
    logic [DATA_W-1:0]         front_next;
    logic [DATA_W-1:0]         rear_reg;
    logic [DATA_W-1:0]         rear_next;
    logic [DATA_W-1:0]         popped_reg;
    logic [DATA_W-1:0]         popped_next;
    cdq_pkg::status_t          status_reg;
    cdq_pkg::status_t          status_next;
    logic                      rd_front_reg;
    logic                      rd_front_next;

    // Slot store with one write port and one registered read port.
    logic [DATA_W-1:0]         mem [cdq_pkg::DEPTH];
    logic [DATA_W-1:0]         rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      mem_we;
    logic [IDX_W-1:0]          wr_addr;

    // Decoded request and derived values.
    cdq_pkg::mode_t            req;
    logic                      is_push;
    logic                      push_ok;
    logic                      pop_ok;
    logic [CNT_W-1:0]          eff_cap;
    logic [IDX_W-1:0]          head_inc;
    logic [IDX_W-1:0]          head_dec;
    logic [IDX_W-1:0]          tail_inc;
    logic [IDX_W-1:0]          tail_dec;

    // Capacity in use: zero counts as one, anything above the depth saturates.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(cdq_pkg::DEPTH))
        begin
            eff_cap = CNT_W'(cdq_pkg::DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // Circular index steps within the capacity in use.
    always_comb
    begin
        head_inc = (CNT_W'(head_reg) + CNT_W'(1) >= eff_cap) ? '0 : head_reg + IDX_W'(1);
        tail_inc = (CNT_W'(tail_reg) + CNT_W'(1) >= eff_cap) ? '0 : tail_reg + IDX_W'(1);
        head_dec = (head_reg == '0) ? IDX_W'(eff_cap - CNT_W'(1)) : head_reg - IDX_W'(1);
        tail_dec = (tail_reg == '0) ? IDX_W'(eff_cap - CNT_W'(1)) : tail_reg - IDX_W'(1);
    end

    // Request decode.
    assign req            = cdq_pkg::mode_t'(mode);
    assign is_push        = (req == cdq_pkg::MODE_PUSH_FRONT) || (req == cdq_pkg::MODE_PUSH_REAR);
    assign push_ok        = is_push && (count_reg < eff_cap);
    assign pop_ok         = !is_push && (count_reg != '0);
    assign stat.need_read = pop_ok;

    // Next-state logic for one step.
    always_comb
    begin
        cap_next      = cap_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        front_next    = front_reg;
        rear_next     = rear_reg;
        popped_next   = popped_reg;
        status_next   = status_reg;
        rd_front_next = rd_front_reg;
        mem_we        = 1'b0;
        wr_addr       = '0;
        rd_addr       = head_inc;

        if (cfg_wr_en)
        begin
            // A capacity write empties the queue.
            cap_next   = cfg_wr_data;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (cmd.take)
        begin
            popped_next = '0;
            status_next = cdq_pkg::STAT_OK;
            if (is_push)
            begin
                if (!push_ok)
                begin
                    status_next = cdq_pkg::STAT_FULL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == '0)
                    begin
                        // First item goes to slot zero from either end.
                        head_next  = '0;
                        tail_next  = '0;
                        wr_addr    = '0;
                        front_next = data_in;
                        rear_next  = data_in;
                    end
                    else if (req == cdq_pkg::MODE_PUSH_FRONT)
                    begin
                        head_next  = head_dec;
                        wr_addr    = head_dec;
                        front_next = data_in;
                    end
                    else
                    begin
                        tail_next  = tail_inc;
                        wr_addr    = tail_inc;
                        rear_next  = data_in;
                    end
                end
            end
            else
            begin
                if (!pop_ok)
                begin
                    status_next = cdq_pkg::STAT_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (req == cdq_pkg::MODE_POP_FRONT)
                    begin
                        popped_next   = front_reg;
                        head_next     = head_inc;
                        rd_addr       = head_inc;
                        rd_front_next = 1'b1;
                    end
                    else
                    begin
                        popped_next   = rear_reg;
                        tail_next     = tail_dec;
                        rd_addr       = tail_dec;
                        rd_front_next = 1'b0;
                    end
                    // Last item gone: both indices return to slot zero.
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
        end
        else if (cmd.finish)
        begin
            // The new end element read from the store refreshes its cache.
            if (rd_front_reg)
            begin
                front_next = rd_data_reg;
            end
            else
            begin
                rear_next = rd_data_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= cdq_pkg::CAP_RESET;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        front_reg    <= front_next;
        rear_reg     <= rear_next;
        popped_reg   <= popped_next;
        status_reg   <= status_next;
        rd_front_reg <= rd_front_next;
    end

    // Store write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= data_in;
        end
    end

    // Store read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Result fields.
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign front_value  = (count_reg != '0) ? front_reg : '0;
    assign rear_value   = (count_reg != '0) ? rear_reg : '0;
    assign entry_count  = cdq_pkg::ENTRY_W'(count_reg);
    assign is_empty     = (count_reg == '0);
    assign is_full      = (count_reg == eff_cap);

    // The count never runs past the capacity in use.
    `CDQ_ASSERT(a_count_bound, count_reg <= eff_cap, "count above capacity")
    // An empty queue has both indices at slot zero.
    `CDQ_ASSERT(a_empty_idx, count_reg == '0 |-> head_reg == '0 && tail_reg == '0, "indices off zero")
    // A refused request leaves the count untouched.
    `CDQ_ASSERT(a_refused_hold, cmd.take && !cfg_wr_en && !push_ok && !pop_ok |=> count_reg == $past(count_reg), "refused request changed count")

endmodule

/* design/circular_deque_core.sv */
// Top level of the circular deque: controller and datapath joined to the channels.
//
// Usage:
//   in_ch carries one request item: mode (push front, push rear, pop front,
//   pop rear) and data_in, the value to push. out_ch returns exactly one
//   result item per request: status, popped value, the front and rear values
//   after the step, the entry count and the empty and full flags.
//   cfg_wr_en with cfg_wr_data writes the capacity (1 to 16 entries) and
//   empties the queue; write it only while no request is in flight.
// Timing:
//   A push or a refused request offers its result in the cycle after it is
//   taken; a successful pop passes through the read step (S_READ) before
//   S_DONE, since the new end element is fetched through the registered
//   read port of the slot store. The next request is taken the cycle after the
//   result is taken, so a new request is never taken while one is in flight.
// Reset:
//   rst_n clears the queue and sets the capacity to 16.
// Stalls:
//   While out_ch.ready is low the result is held unchanged and in_ch.ready
//   stays low.
module circular_deque_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cdq_pkg::CAP_W-1:0]   cfg_wr_data,
    cdq_in_if.sink                      in_ch,
    cdq_out_if.source                   out_ch
);

    cdq_pkg::cdq_cmd_t  cmd;
    cdq_pkg::cdq_stat_t stat;

    // Sequencing of each item.
    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    // Store, indices and result registers.
    cdq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .mode         (in_ch.mode),
        .data_in      (in_ch.data_in),
        .cmd          (cmd),
        .stat         (stat),
        .status       (out_ch.status),
        .popped_value (out_ch.popped_value),
        .front_value  (out_ch.front_value),
        .rear_value   (out_ch.rear_value),
        .entry_count  (out_ch.entry_count),
        .is_empty     (out_ch.is_empty),
        .is_full      (out_ch.is_full)
    );

endmodule
